// File: src/pivl_pkg.sv
// Shared types and constants for the PI velocity loop with feedforward.
`timescale 1ns / 1ps
`default_nettype none

package pivl_pkg;

    localparam int MUL_W  = 18;
    localparam int MUL_PW = 2 * MUL_W;

    localparam int RATIO_FRAC  = 14;
    localparam int TICK_FRAC   = 16;
    localparam int ANGLE_FRAC  = 13;
    localparam int SLOPE4_FRAC = 4;
    localparam int GAIN_FRAC   = 8;

    localparam int FIELD_W = 17;

    typedef enum logic [1:0] {
        OP_REMOTE  = 2'd0,
        OP_DIRECT  = 2'd1,
        OP_HOST    = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_INTEG_LIMIT   = 3'd2,
        REG_TICK_PERIOD   = 3'd3,
        REG_SPEED_CEILING = 3'd4,
        REG_FF_SLOPE      = 3'd5,
        REG_FF_BIAS       = 3'd6,
        REG_STEER_SLOPE   = 3'd7
    } t_reg;

    localparam logic [15:0] RST_PROP_GAIN     = 16'd3840;
    localparam logic [15:0] RST_INTEG_GAIN    = 16'd256;
    localparam logic [14:0] RST_INTEG_LIMIT   = 15'd5120;
    localparam logic [15:0] RST_TICK_PERIOD   = 16'd655;
    localparam logic [14:0] RST_SPEED_CEILING = 15'd3072;
    localparam logic [15:0] RST_FF_SLOPE      = 16'd2764;
    localparam logic [15:0] RST_FF_BIAS       = 16'd622;
    localparam logic [15:0] RST_STEER_SLOPE   = 16'hB324;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_MUL_TGT = 10'b00_0000_0010,
        ST_ERR     = 10'b00_0000_0100,
        ST_MUL_INT = 10'b00_0000_1000,
        ST_INT     = 10'b00_0001_0000,
        ST_MUL_FF  = 10'b00_0010_0000,
        ST_ACC_FF  = 10'b00_0100_0000,
        ST_MUL_I   = 10'b00_1000_0000,
        ST_ACC_I   = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

// File: src/pivl_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module pivl_mul (
    input  wire                                  i_clk,
    input  wire logic signed [pivl_pkg::MUL_W-1:0]  i_a,
    input  wire logic signed [pivl_pkg::MUL_W-1:0]  i_b,
    output logic signed [pivl_pkg::MUL_PW-1:0]      o_prod
);
    import pivl_pkg::*;

    logic signed [MUL_PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: src/pi_velocity_loop_with_feedforward_core.sv
// Top level: sequenced PI velocity loop with feedforward and clamped integrator.
// One shared 18x18 multiplier is stepped through five products by the sequencer in velocity modes;
// direct mode skips them. A new item is taken only in the idle state, after the last one is done.
// Input is taken while a finished result waits; the next result holds until that one goes.
// Reset (synchronous, active low) clears the integrator and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pi_velocity_loop_with_feedforward_core #(
    parameter int VEL_FRAC_BITS = 10,
    parameter int CMD_WIDTH     = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [2:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [1:0]        i_operation,
    input  wire  signed [15:0] i_measured_speed,
    input  wire  signed [15:0] i_host_speed,
    input  wire  signed [15:0] i_host_angle,
    input  wire  signed [15:0] i_remote_ratio,
    input  wire  signed [15:0] i_remote_steer,
    input  wire  [15:0]       i_remote_throttle_raw,
    input  wire  [15:0]       i_remote_steer_raw,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [16:0] o_motor_cmd,
    output logic signed [16:0] o_servo_cmd,
    output logic              o_is_direct,
    output logic signed [16:0] o_speed_error,
    output logic signed [15:0] o_integ_value,
    output logic signed [15:0] o_ff_term,
    output logic              o_saturated
);
    import pivl_pkg::*;

    localparam int ACC_W   = 40;
    localparam int FRAC    = GAIN_FRAC + VEL_FRAC_BITS;
    localparam int BIAS_SH = FRAC - SLOPE4_FRAC;
    localparam int SERVO_SH = SLOPE4_FRAC + ANGLE_FRAC;

    localparam logic signed [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) <<< FRAC) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] CMD_HI = (ACC_W'(1) <<< (CMD_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] CMD_LO = ~CMD_HI;
    localparam logic signed [ACC_W-1:0] A16_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] A16_MIN = ~A16_MAX;
    localparam logic signed [MUL_PW-1:0] P16_MAX = MUL_PW'(32767);
    localparam logic signed [MUL_PW-1:0] P16_MIN = ~P16_MAX;
    localparam logic signed [MUL_PW-1:0] SERVO_MASK = (MUL_PW'(1) <<< SERVO_SH) - MUL_PW'(1);

    // configuration registers
    logic [15:0] r_prop_gain, r_integ_gain, r_tick_period;
    logic [14:0] r_integ_limit, r_speed_ceiling;
    logic signed [15:0] r_ff_slope, r_ff_bias, r_steer_slope;

    // sequencer and item registers
    t_state r_state;
    logic   r_host, r_direct;
    logic signed [15:0] r_measured, r_host_speed, r_angle, r_ratio, r_rsteer;
    logic [15:0] r_raw_thr, r_raw_steer;
    logic signed [15:0] r_target;
    logic signed [16:0] r_err, r_servo;
    logic signed [15:0] r_integ;
    logic signed [15:0] r_ff_int;
    logic signed [ACC_W-1:0] r_acc;

    // output register
    logic r_out_valid;
    logic signed [16:0] r_motor_o, r_servo_o, r_err_o;
    logic signed [15:0] r_integ_o, r_ff_o;
    logic r_direct_o, r_sat_o;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [MUL_PW-1:0] prod;

    logic signed [MUL_PW-1:0] tgt_wide, servo_rnd, servo_wide, step_wide, isum, lim_p, lim_n;
    logic signed [15:0] tgt_sel;
    logic signed [ACC_W-1:0] prod_ext, bias_ext, acc_rnd, acc_trunc, cmd_clamped;
    logic out_free, cmd_sat;

    pivl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_TGT: begin
                if (r_host) begin
                    mul_a = MUL_W'(r_steer_slope);
                    mul_b = MUL_W'(r_angle);
                end else begin
                    mul_a = MUL_W'({1'b0, r_speed_ceiling});
                    mul_b = MUL_W'(r_ratio);
                end
            end
            ST_MUL_INT: begin
                mul_a = MUL_W'(r_err);
                mul_b = MUL_W'({1'b0, r_tick_period});
            end
            ST_MUL_FF: begin
                mul_a = MUL_W'(r_ff_slope);
                mul_b = MUL_W'(r_target);
            end
            ST_ACC_FF: begin
                mul_a = MUL_W'({1'b0, r_prop_gain});
                mul_b = MUL_W'(r_err);
            end
            ST_MUL_I: begin
                mul_a = MUL_W'({1'b0, r_integ_gain});
                mul_b = MUL_W'(r_integ);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        tgt_wide = prod >>> RATIO_FRAC;
        if (tgt_wide > P16_MAX) begin
            tgt_sel = 16'sh7FFF;
        end else if (tgt_wide < P16_MIN) begin
            tgt_sel = -16'sh8000;
        end else begin
            tgt_sel = tgt_wide[15:0];
        end
        if (r_host) begin
            tgt_sel = r_host_speed;
        end

        servo_rnd  = prod + (prod[MUL_PW-1] ? SERVO_MASK : '0);
        servo_wide = servo_rnd >>> SERVO_SH;

        step_wide = prod >>> TICK_FRAC;
        isum      = step_wide + MUL_PW'(r_integ);
        lim_p     = MUL_PW'({1'b0, r_integ_limit});
        lim_n     = -lim_p;

        prod_ext  = ACC_W'(prod);
        bias_ext  = ACC_W'(r_ff_bias) <<< BIAS_SH;
        acc_rnd   = r_acc + (r_acc[ACC_W-1] ? FRAC_MASK : '0);
        acc_trunc = acc_rnd >>> FRAC;

        cmd_sat = (acc_trunc > CMD_HI) || (acc_trunc < CMD_LO);
        if (acc_trunc > CMD_HI) begin
            cmd_clamped = CMD_HI;
        end else if (acc_trunc < CMD_LO) begin
            cmd_clamped = CMD_LO;
        end else begin
            cmd_clamped = acc_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= RST_PROP_GAIN;
            r_integ_gain    <= RST_INTEG_GAIN;
            r_integ_limit   <= RST_INTEG_LIMIT;
            r_tick_period   <= RST_TICK_PERIOD;
            r_speed_ceiling <= RST_SPEED_CEILING;
            r_ff_slope      <= RST_FF_SLOPE;
            r_ff_bias       <= RST_FF_BIAS;
            r_steer_slope   <= RST_STEER_SLOPE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg'(i_cfg_index))
                REG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                REG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data;
                REG_INTEG_LIMIT:   r_integ_limit   <= i_cfg_data[14:0];
                REG_TICK_PERIOD:   r_tick_period   <= i_cfg_data;
                REG_SPEED_CEILING: r_speed_ceiling <= i_cfg_data[14:0];
                REG_FF_SLOPE:      r_ff_slope      <= i_cfg_data;
                REG_FF_BIAS:       r_ff_bias       <= i_cfg_data;
                REG_STEER_SLOPE:   r_steer_slope   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_direct <= (t_op'(i_operation) == OP_DIRECT);
                        r_host   <= (t_op'(i_operation) == OP_HOST);
                        if (t_op'(i_operation) == OP_DIRECT) begin
                            r_integ <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_MUL_TGT;
                        end
                    end
                end
                ST_MUL_TGT: r_state <= ST_ERR;
                ST_ERR: begin
                    r_target <= tgt_sel;
                    r_err    <= 17'(tgt_sel) - 17'(r_measured);
                    r_servo  <= r_host ? servo_wide[16:0] : 17'(r_rsteer);
                    r_state  <= ST_MUL_INT;
                end
                ST_MUL_INT: r_state <= ST_INT;
                ST_INT: begin
                    if (isum > lim_p) begin
                        r_integ <= lim_p[15:0];
                    end else if (isum < lim_n) begin
                        r_integ <= lim_n[15:0];
                    end else begin
                        r_integ <= isum[15:0];
                    end
                    r_acc   <= bias_ext;
                    r_state <= ST_MUL_FF;
                end
                ST_MUL_FF: r_state <= ST_ACC_FF;
                ST_ACC_FF: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= ST_MUL_I;
                end
                ST_MUL_I: begin
                    if (acc_trunc > A16_MAX) begin
                        r_ff_int <= 16'sh7FFF;
                    end else if (acc_trunc < A16_MIN) begin
                        r_ff_int <= -16'sh8000;
                    end else begin
                        r_ff_int <= acc_trunc[15:0];
                    end
                    r_acc   <= r_acc + prod_ext;
                    r_state <= ST_ACC_I;
                end
                ST_ACC_I: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // capture item payload and load the result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_measured   <= i_measured_speed;
            r_host_speed <= i_host_speed;
            r_angle      <= i_host_angle;
            r_ratio      <= i_remote_ratio;
            r_rsteer     <= i_remote_steer;
            r_raw_thr    <= i_remote_throttle_raw;
            r_raw_steer  <= i_remote_steer_raw;
        end
        if (r_state == ST_DONE && out_free) begin
            r_direct_o <= r_direct;
            if (r_direct) begin
                r_motor_o <= {1'b0, r_raw_thr};
                r_servo_o <= {1'b0, r_raw_steer};
                r_err_o   <= '0;
                r_integ_o <= '0;
                r_ff_o    <= '0;
                r_sat_o   <= 1'b0;
            end else begin
                r_motor_o <= cmd_clamped[16:0];
                r_servo_o <= r_servo;
                r_err_o   <= r_err;
                r_integ_o <= r_integ;
                r_ff_o    <= r_ff_int;
                r_sat_o   <= cmd_sat;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_cmd   = r_motor_o;
    assign o_servo_cmd   = r_servo_o;
    assign o_is_direct   = r_direct_o;
    assign o_speed_error = r_err_o;
    assign o_integ_value = r_integ_o;
    assign o_ff_term     = r_ff_o;
    assign o_saturated   = r_sat_o;

endmodule

`default_nettype wire

// File: src/pivl_checker.sv
// Port-level checker for the PI velocity loop, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pivl_checker #(
    parameter int CMD_WIDTH = 16
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_ready,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire signed [16:0] o_motor_cmd,
    input wire               o_is_direct,
    input wire signed [16:0] o_speed_error,
    input wire signed [15:0] o_integ_value,
    input wire signed [15:0] o_ff_term,
    input wire               o_saturated
);
    import pivl_pkg::*;

    localparam logic [FIELD_W-1:0] HI17 = FIELD_W'((64'sd1 <<< (CMD_WIDTH - 1)) - 64'sd1);
    localparam logic [FIELD_W-1:0] LO17 = FIELD_W'(-(64'sd1 <<< (CMD_WIDTH - 1)));

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_motor_cmd))
        else $error("stalled result changed");

    a_direct_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_direct |->
            o_speed_error == 17'sd0 && o_integ_value == 16'sd0 &&
            o_ff_term == 16'sd0 && !o_saturated)
        else $error("direct result carries loop fields");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_motor_cmd == HI17 || o_motor_cmd == LO17)
        else $error("saturated result not at a limit");

endmodule

bind pi_velocity_loop_with_feedforward_core pivl_checker #(.CMD_WIDTH(CMD_WIDTH)) u_pivl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_motor_cmd   (o_motor_cmd),
    .o_is_direct   (o_is_direct),
    .o_speed_error (o_speed_error),
    .o_integ_value (o_integ_value),
    .o_ff_term     (o_ff_term),
    .o_saturated   (o_saturated)
);

`default_nettype wire
